/* hw/rtl/ipcsum_pkg.sv */
// Package: shared types and constants for the IPv4/TCP checksum recompute block.
package ipcsum_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_BAD_IHL = 2'd1;
  localparam status_t STATUS_SHORT   = 2'd2;

  localparam int IHL_MASK        = 'h0F;
  localparam int IP_CHK_OFF      = 10;
  localparam int ADDR_FIRST_OFF  = 12;
  localparam int ADDR_LAST_OFF   = 18;
  localparam int TCP_CHK_OFF     = 16;
  localparam int MIN_HDR_BYTES   = 20;
  localparam int MIN_SEG_BYTES   = 20;
  localparam logic [15:0] PROTO_TCP = 16'd6;

endpackage

/* hw/rtl/ipcsum_if.sv */
// Interfaces: packet byte stream channel and checksum result channel.
interface ipcsum_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ipcsum_out_if;
  logic                  valid;
  logic                  ready;
  logic [15:0]           ip_checksum;
  logic [15:0]           tcp_checksum;
  ipcsum_pkg::status_t   status;

  modport source (output valid, output ip_checksum, output tcp_checksum, output status,
                  input ready);
  modport sink   (input valid, input ip_checksum, input tcp_checksum, input status,
                  output ready);
endinterface

/* hw/rtl/ipv4_tcp_checksum_recompute.sv */
// Top level: streaming IPv4 header and TCP checksum recompute.
//
//   Channel  Dir  Payload                               Transfer
//   in_ch    in   data_byte[7:0], last                  valid & ready
//   out_ch   out  ip_checksum, tcp_checksum, status[1:0] valid & ready
//
// One byte per cycle while in_ch.ready is high.
// The per-byte end-around-carry add sets the byte rate; the pseudo-header protocol
// and the length are added in a second stage between the final and output registers.
// Synchronous active-low reset clears the running sums and the valid flags.
// in_ch.ready drops only while both the final and output registers hold results
// and out_ch.ready is low.
module ipv4_tcp_checksum_recompute #(
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  ipcsum_in_if.sink           in_ch,
  ipcsum_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int WW    = CNT_W + 1;

  function automatic logic [15:0] oc_fold(input logic [17:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // running state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [5:0]       hdr_r, hdr_nxt;
  logic [15:0]      ip_r, ip_nxt;
  logic [15:0]      tcp_r, tcp_nxt;
  logic [7:0]       held_r, held_nxt;

  // final register
  logic             fin_valid_r;
  logic [15:0]      fin_ip_r, fin_tcp_r;
  logic [CNT_W-1:0] fin_n_r;
  logic [5:0]       fin_hdr_r;

  // output register
  logic                out_valid_r;
  logic [15:0]         out_ip_r, out_tcp_r;
  ipcsum_pkg::status_t out_status_r;

  logic             in_xfer, fin_move;
  logic             proc;
  logic [CNT_W-1:0] n_cnt;
  logic [5:0]       hb;
  logic             word_en;
  logic [WW-1:0]    off_w, hb_w;
  logic [15:0]      word;
  logic             in_hdr, ip_en, seg_en, pseudo_en;
  logic [15:0]      ip_sum_new, tcp_sum_new;

  assign fin_move    = fin_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !fin_valid_r || fin_move;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    proc  = (WW'(count_r) < WW'(MAX_PACKET_BYTES));
    n_cnt = proc ? count_r + CNT_W'(1) : count_r;
    hb    = (count_r == '0) ? {in_ch.data_byte[3:0], 2'b00} : hdr_r;
    hb_w  = WW'(hb);

    word_en = 1'b0;
    off_w   = '0;
    word    = '0;
    if (proc && count_r[0]) begin
      word_en = 1'b1;
      off_w   = WW'(count_r) - WW'(1);
      word    = {held_r, in_ch.data_byte};
    end else if (in_ch.last && n_cnt[0]) begin
      word_en = 1'b1;
      off_w   = WW'(n_cnt) - WW'(1);
      word    = {(proc ? in_ch.data_byte : held_r), 8'h00};
    end

    in_hdr    = off_w < hb_w;
    ip_en     = word_en && in_hdr && (off_w != WW'(ipcsum_pkg::IP_CHK_OFF));
    seg_en    = word_en && !in_hdr &&
                (off_w != hb_w + WW'(ipcsum_pkg::TCP_CHK_OFF));
    pseudo_en = word_en && (off_w >= WW'(ipcsum_pkg::ADDR_FIRST_OFF)) &&
                (off_w <= WW'(ipcsum_pkg::ADDR_LAST_OFF));

    ip_sum_new  = oc_fold({2'b00, ip_r} + {2'b00, (ip_en ? word : 16'd0)});
    tcp_sum_new = oc_fold({2'b00, tcp_r} + {2'b00, (seg_en ? word : 16'd0)}
                          + {2'b00, (pseudo_en ? word : 16'd0)});

    held_nxt  = (proc && !count_r[0]) ? in_ch.data_byte : held_r;
    count_nxt = n_cnt;
    hdr_nxt   = hb;
    ip_nxt    = ip_sum_new;
    tcp_nxt   = tcp_sum_new;
    if (in_ch.last) begin
      held_nxt  = '0;
      count_nxt = '0;
      hdr_nxt   = '0;
      ip_nxt    = '0;
      tcp_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hdr_r   <= '0;
      ip_r    <= '0;
      tcp_r   <= '0;
      held_r  <= '0;
    end else if (in_xfer) begin
      count_r <= count_nxt;
      hdr_r   <= hdr_nxt;
      ip_r    <= ip_nxt;
      tcp_r   <= tcp_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (in_xfer && in_ch.last) begin
      fin_valid_r <= 1'b1;
    end else if (fin_move) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.last) begin
      fin_ip_r  <= ip_sum_new;
      fin_tcp_r <= tcp_sum_new;
      fin_n_r   <= n_cnt;
      fin_hdr_r <= hb;
    end
  end

  // final stage: status, pseudo-header protocol and segment length
  logic [WW-1:0]       fin_n_w, fin_hdr_w;
  logic [15:0]         seg_len;
  logic [15:0]         tcp_final;
  ipcsum_pkg::status_t status_nxt;
  logic [15:0]         ip_out_nxt, tcp_out_nxt;

  always_comb begin
    fin_n_w   = WW'(fin_n_r);
    fin_hdr_w = WW'(fin_hdr_r);
    seg_len   = 16'(fin_n_w - fin_hdr_w);
    tcp_final = oc_fold({2'b00, fin_tcp_r} + {2'b00, ipcsum_pkg::PROTO_TCP}
                        + {2'b00, seg_len});
    status_nxt  = ipcsum_pkg::STATUS_OK;
    ip_out_nxt  = '0;
    tcp_out_nxt = '0;
    if (fin_hdr_r < 6'(ipcsum_pkg::MIN_HDR_BYTES)) begin
      status_nxt = ipcsum_pkg::STATUS_BAD_IHL;
    end else if (fin_n_w < fin_hdr_w + WW'(ipcsum_pkg::MIN_SEG_BYTES)) begin
      status_nxt = ipcsum_pkg::STATUS_SHORT;
    end else begin
      ip_out_nxt  = ~fin_ip_r;
      tcp_out_nxt = ~tcp_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      out_ip_r     <= ip_out_nxt;
      out_tcp_r    <= tcp_out_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ip_checksum  = out_ip_r;
  assign out_ch.tcp_checksum = out_tcp_r;
  assign out_ch.status       = out_status_r;

endmodule

/* dv/ipv4_tcp_checksum_recompute_tb.sv */
`timescale 1ns / 100ps
// Testbench for ipv4_tcp_checksum_recompute: directed packet table, then random packets.
module ipv4_tcp_checksum_recompute_tb;

  localparam int MAX_PKT_BYTES = 65535;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_BYTES    = 120;
  localparam int RAND_PKTS     = 3;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TAIL_CYCLES   = 10;
  localparam int CYCLE_LIMIT   = 1500000;

  typedef enum logic [1:0] {FILL_CONST, FILL_RAND, FILL_RAMP} fill_t;

  typedef struct packed {
    logic [15:0]         ip_chk;
    logic [15:0]         tcp_chk;
    ipcsum_pkg::status_t status;
  } csum_result_t;

  typedef struct packed {
    logic [7:0]   first;
    logic [16:0]  len;
    fill_t        fill;
    logic [7:0]   fill_val;
    logic         typed;
    csum_result_t want;
  } pkt_row_t;

  localparam csum_result_t NO_WANT = '0;
  localparam int NUM_ROWS = 16;

  // first byte, length, fill, fill value, typed expectation, expectation
  pkt_row_t pkt_rows [NUM_ROWS] = '{
    '{8'h45, 17'd40, FILL_CONST, 8'h00, 1'b1, '{16'hBAFF, 16'hFFE5, ipcsum_pkg::STATUS_OK}},
    '{8'h00, 17'd1, FILL_CONST, 8'h00, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_BAD_IHL}},
    '{8'hFF, 17'd1, FILL_CONST, 8'hFF, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_SHORT}},
    '{8'h44, 17'd24, FILL_RAND, 8'h00, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_BAD_IHL}},
    '{8'h45, 17'd15, FILL_RAND, 8'h00, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_SHORT}},
    '{8'h4F, 17'd30, FILL_RAND, 8'h00, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_SHORT}},
    '{8'h4F, 17'd79, FILL_RAND, 8'h00, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_SHORT}},
    '{8'h45, 17'd39, FILL_RAND, 8'h00, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_SHORT}},
    '{8'h00, 17'd24, FILL_CONST, 8'h00, 1'b1, '{16'h0000, 16'h0000, ipcsum_pkg::STATUS_BAD_IHL}},
    '{8'h45, 17'd40,  FILL_RAND,  8'h00, 1'b0, NO_WANT},
    '{8'h45, 17'd41,  FILL_RAND,  8'h00, 1'b0, NO_WANT},
    '{8'hFF, 17'd80,  FILL_CONST, 8'hFF, 1'b0, NO_WANT},
    '{8'h45, 17'd41,  FILL_CONST, 8'hFF, 1'b0, NO_WANT},
    '{8'h4F, 17'd81,  FILL_RAND,  8'h00, 1'b0, NO_WANT},
    '{8'h45, 17'd64,  FILL_RAMP,  8'h00, 1'b0, NO_WANT},
    '{8'h46, 17'd70,  FILL_RAND,  8'h00, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ipcsum_in_if  in_ch ();
  ipcsum_out_if out_ch ();

  ipv4_tcp_checksum_recompute #(.MAX_PACKET_BYTES(MAX_PKT_BYTES)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  csum_result_t pending_csums [$];
  csum_result_t mon_want;
  int unsigned  errors = 0;
  int unsigned  rand_bytes = 0;
  int unsigned  rand_pkts = 0;
  int unsigned  cycle_count = 0;
  bit           hold_req = 1'b0;
  bit           hold_on = 1'b0;

  // running packet state
  int unsigned pk_count = 0;
  logic [5:0]  pk_hdr_len = '0;
  logic [15:0] pk_ip_sum = '0;
  logic [15:0] pk_tcp_sum = '0;
  logic [7:0]  pk_held = '0;

  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic void route_word(int unsigned off, logic [15:0] w);
    if (off < pk_hdr_len) begin
      if (off != ipcsum_pkg::IP_CHK_OFF) pk_ip_sum = ones_add(pk_ip_sum, w);
    end else if (off - pk_hdr_len != ipcsum_pkg::TCP_CHK_OFF) begin
      pk_tcp_sum = ones_add(pk_tcp_sum, w);
    end
    // address words also feed the pseudo-header
    if (off >= ipcsum_pkg::ADDR_FIRST_OFF && off <= ipcsum_pkg::ADDR_LAST_OFF)
      pk_tcp_sum = ones_add(pk_tcp_sum, w);
  endfunction

  function automatic bit fold_byte(logic [7:0] b, logic lst, output csum_result_t r);
    int unsigned n;
    int unsigned seg;
    r = NO_WANT;
    if (pk_count < MAX_PKT_BYTES) begin
      if (pk_count == 0) pk_hdr_len = 6'((b & ipcsum_pkg::IHL_MASK) * 4);
      if (pk_count[0] == 1'b0) pk_held = b;
      else route_word(pk_count - 1, {pk_held, b});
      pk_count++;
    end
    if (!lst) return 1'b0;
    n = pk_count;
    if (n[0]) route_word(n - 1, {pk_held, 8'h00});
    r.status = ipcsum_pkg::STATUS_OK;
    if (pk_hdr_len < ipcsum_pkg::MIN_HDR_BYTES) begin
      r.status = ipcsum_pkg::STATUS_BAD_IHL;
    end else if (n < pk_hdr_len || n - pk_hdr_len < ipcsum_pkg::MIN_SEG_BYTES) begin
      r.status = ipcsum_pkg::STATUS_SHORT;
    end else begin
      seg = n - pk_hdr_len;
      pk_tcp_sum = ones_add(pk_tcp_sum, ipcsum_pkg::PROTO_TCP);
      pk_tcp_sum = ones_add(pk_tcp_sum, seg[15:0]);
      r.ip_chk  = ~pk_ip_sum;
      r.tcp_chk = ~pk_tcp_sum;
    end
    pk_count   = 0;
    pk_hdr_len = '0;
    pk_ip_sum  = '0;
    pk_tcp_sum = '0;
    pk_held    = '0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(logic [7:0] b, logic lst, logic typed, csum_result_t want,
                           bit gaps);
    int unsigned idle;
    csum_result_t r;
    idle = gaps ? pick_gap() : 0;
    if (idle != 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (fold_byte(b, lst, r)) pending_csums.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic send_random_packet(bit short_only);
    logic [7:0] first;
    int unsigned ihl;
    int unsigned len;
    int unsigned kind;
    bit calm;
    kind  = $urandom_range(0, 99);
    ihl   = (kind < 80) ? $urandom_range(5, 15) : $urandom_range(0, 4);
    first = {4'($urandom), 4'(ihl)};
    if (short_only) len = $urandom_range(1, 3);
    else if (kind < 65) len = ihl * 4 + ipcsum_pkg::MIN_SEG_BYTES + $urandom_range(0, 40);
    else if (kind < 70) len = ihl * 4 + ipcsum_pkg::MIN_SEG_BYTES + $urandom_range(41, 200);
    else if (kind < 80) len = $urandom_range(1, ihl * 4 + ipcsum_pkg::MIN_SEG_BYTES - 1);
    else len = $urandom_range(1, 80);
    calm = short_only || ($urandom_range(0, 4) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte((i == 0) ? first : 8'($urandom), i == len - 1, 1'b0, NO_WANT, !calm);
      rand_bytes++;
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_csums.size() == 0) begin
        $display("%0t: unexpected transfer: ip %h tcp %h status %0d", $time,
                 out_ch.ip_checksum, out_ch.tcp_checksum, out_ch.status);
        errors++;
      end else begin
        mon_want = pending_csums.pop_front();
        check_field("ip_checksum", mon_want.ip_chk, out_ch.ip_checksum);
        check_field("tcp_checksum", mon_want.tcp_chk, out_ch.tcp_checksum);
        check_field("status", {14'd0, mon_want.status}, {14'd0, out_ch.status});
      end
    end
  end

  initial begin : result_sink
    int unsigned open_len;
    int unsigned idle;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_on = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on = 1'b0;
      end else begin
        open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 150)
                                               : $urandom_range(1, 12);
        out_ch.ready <= 1'b1;
        repeat (open_len) @(negedge clk);
        idle = pick_gap();
        if (idle != 0) begin
          out_ch.ready <= 1'b0;
          repeat (idle) @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached, %0d results pending", $time, pending_csums.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] b;
    int unsigned drain;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (pkt_rows[k]) begin
      for (int unsigned i = 0; i < pkt_rows[k].len; i++) begin
        case (pkt_rows[k].fill)
          FILL_CONST: b = pkt_rows[k].fill_val;
          FILL_RAMP:  b = 8'(i);
          default:    b = 8'($urandom);
        endcase
        if (i == 0) b = pkt_rows[k].first;
        send_byte(b, i == pkt_rows[k].len - 1, pkt_rows[k].typed, pkt_rows[k].want,
                  pkt_rows[k].len < 2000);
      end
    end

    while (rand_bytes < RAND_BYTES || rand_pkts < RAND_PKTS) begin
      if (rand_pkts == 1) begin
        // long output stall while short packets keep coming
        in_ch.valid <= 1'b0;
        hold_req = 1'b1;
        wait (hold_on);
        hold_req = 1'b0;
        repeat (30) send_random_packet(1'b1);
      end
      send_random_packet(1'b0);
      rand_pkts++;
    end
    in_ch.valid <= 1'b0;

    drain = 0;
    while (pending_csums.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_csums.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_csums.size());
      errors += pending_csums.size();
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
